/* hdl/rtyuv_pkg.sv */
package rtyuv_pkg;

    // Field widths.
    localparam int SAMPLE_W      = 8;
    localparam int LUMA_MILLI_W  = 18;
    localparam int U_MILLI_W     = 18;
    localparam int CHROMA_MILLI_W = 19;
    localparam int CHROMA_SUM_W  = 21;
    localparam int CHROMA_MAG_W  = 20;
    localparam int CHROMA_QUOT_W = 10;

    // Luma coefficients in thousandths, plus the half-up rounding term.
    localparam int LUMA_R     = 299;
    localparam int LUMA_G     = 587;
    localparam int LUMA_B     = 114;
    localparam int LUMA_ROUND = 500;

    // U and V coefficients in thousandths.
    localparam int U_R = -147;
    localparam int U_G = -289;
    localparam int U_B = 436;
    localparam int V_R = 615;
    localparam int V_G = -515;
    localparam int V_B = -100;

    // Division by 1000 as multiplication by a reciprocal: exact for operands below 2**20.
    localparam int              DIV1000_SHIFT  = 30;
    localparam int              DIV1000_MULT_W = 21;
    localparam logic [20:0]     DIV1000_MULT   = 21'd1073742;

    // Chroma clamp limits, as magnitudes.
    localparam logic [8:0] CHROMA_POS_LIMIT = 9'd127;
    localparam logic [8:0] CHROMA_NEG_LIMIT = 9'd128;

    // Register map.
    localparam int         CFG_ADDR_W            = 3;
    localparam logic       REG_IDX_CHROMA_OFFSET = 1'b0;
    localparam logic [7:0] CHROMA_OFFSET_RESET   = 8'd128;

endpackage

/* hdl/rtyuv_pixel.sv */
module rtyuv_pixel (
    input  logic                                      clk,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]            red,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]            green,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]            blue,
    output logic [rtyuv_pkg::LUMA_MILLI_W-1:0]        luma_milli_reg,
    output logic signed [rtyuv_pkg::U_MILLI_W-1:0]    u_milli_reg,
    output logic signed [rtyuv_pkg::CHROMA_MILLI_W-1:0] v_milli_reg
);
    import rtyuv_pkg::*;

    logic [LUMA_MILLI_W-1:0]          luma_milli_next;
    logic signed [U_MILLI_W-1:0]      u_milli_next;
    logic signed [CHROMA_MILLI_W-1:0] v_milli_next;

    // Weighted sums of one pixel in thousandths.
    always_comb
    begin
        luma_milli_next = LUMA_MILLI_W'(LUMA_R * int'(red) + LUMA_G * int'(green)
                                        + LUMA_B * int'(blue) + LUMA_ROUND);
        u_milli_next    = U_MILLI_W'(U_R * int'(red) + U_G * int'(green)
                                     + U_B * int'(blue));
        v_milli_next    = CHROMA_MILLI_W'(V_R * int'(red) + V_G * int'(green)
                                          + V_B * int'(blue));
    end

    // First pipeline stage.
    always_ff @(posedge clk)
    begin
        luma_milli_reg <= luma_milli_next;
        u_milli_reg    <= u_milli_next;
        v_milli_reg    <= v_milli_next;
    end

endmodule

/* hdl/rtyuv_luma.sv */
module rtyuv_luma (
    input  logic                               clk,
    input  logic [rtyuv_pkg::LUMA_MILLI_W-1:0] luma_milli,
    output logic [rtyuv_pkg::SAMPLE_W-1:0]     luma_reg
);
    import rtyuv_pkg::*;

    localparam int PROD_W = LUMA_MILLI_W + DIV1000_MULT_W;

    logic [LUMA_MILLI_W-1:0] milli_reg;
    logic [PROD_W-1:0]       prod_next;
    logic [SAMPLE_W-1:0]     quot_reg;

    // The rounded value divided by 1000 never exceeds 255, so no clamp is needed.
    assign prod_next = PROD_W'(milli_reg) * PROD_W'(DIV1000_MULT);

    // Stage two aligns with the chroma sums, stage three holds the quotient,
    // stage four is the output register.
    always_ff @(posedge clk)
    begin
        milli_reg <= luma_milli;
        quot_reg  <= prod_next[DIV1000_SHIFT +: SAMPLE_W];
        luma_reg  <= quot_reg;
    end

endmodule

/* hdl/rtyuv_chroma.sv */
module rtyuv_chroma (
    input  logic                                        clk,
    input  logic signed [rtyuv_pkg::CHROMA_MILLI_W-1:0] milli_a,
    input  logic signed [rtyuv_pkg::CHROMA_MILLI_W-1:0] milli_b,
    input  logic signed [rtyuv_pkg::CHROMA_MILLI_W-1:0] milli_c,
    input  logic signed [rtyuv_pkg::CHROMA_MILLI_W-1:0] milli_d,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]              offset,
    output logic [rtyuv_pkg::SAMPLE_W-1:0]              chroma_reg
);
    import rtyuv_pkg::*;

    localparam int PROD_W = CHROMA_MAG_W + DIV1000_MULT_W;

    logic signed [CHROMA_SUM_W-1:0] sum_next;
    logic [CHROMA_MAG_W-1:0]        mag_next;
    logic                           neg2_reg;
    logic [CHROMA_MAG_W-1:0]        mag2_reg;
    logic [PROD_W-1:0]              prod_next;
    logic                           neg3_reg;
    logic [CHROMA_QUOT_W-1:0]       quot3_reg;
    logic [CHROMA_QUOT_W:0]         rounded;
    logic [8:0]                     mag4;
    logic [SAMPLE_W-1:0]            limited;
    logic [SAMPLE_W-1:0]            signed_val;
    logic [SAMPLE_W-1:0]            chroma_next;

    // Stage two: sum of the four pixels, split into sign and magnitude.
    always_comb
    begin
        sum_next = CHROMA_SUM_W'(milli_a) + CHROMA_SUM_W'(milli_b)
                 + CHROMA_SUM_W'(milli_c) + CHROMA_SUM_W'(milli_d);
        mag_next = sum_next[CHROMA_SUM_W-1] ? CHROMA_MAG_W'(-sum_next)
                                            : CHROMA_MAG_W'(sum_next);
    end

    // Stage three: magnitude divided by 1000, truncated toward zero.
    assign prod_next = PROD_W'(mag2_reg) * PROD_W'(DIV1000_MULT);

    // Stage four: push 2 away from zero, divide by 4, clamp, restore sign, add offset.
    // A quotient of zero gives zero whatever its sign.
    always_comb
    begin
        rounded = {1'b0, quot3_reg} + (CHROMA_QUOT_W + 1)'(2);
        mag4    = rounded[CHROMA_QUOT_W:2];
        if (neg3_reg)
        begin
            limited    = (mag4 > CHROMA_NEG_LIMIT) ? CHROMA_NEG_LIMIT[SAMPLE_W-1:0]
                                                   : mag4[SAMPLE_W-1:0];
            signed_val = SAMPLE_W'(~limited + SAMPLE_W'(1));
        end
        else
        begin
            limited    = (mag4 > CHROMA_POS_LIMIT) ? CHROMA_POS_LIMIT[SAMPLE_W-1:0]
                                                   : mag4[SAMPLE_W-1:0];
            signed_val = limited;
        end
        chroma_next = signed_val + offset;
    end

    always_ff @(posedge clk)
    begin
        neg2_reg   <= sum_next[CHROMA_SUM_W-1];
        mag2_reg   <= mag_next;
        neg3_reg   <= neg2_reg;
        quot3_reg  <= prod_next[DIV1000_SHIFT +: CHROMA_QUOT_W];
        chroma_reg <= chroma_next;
    end

endmodule

/* hdl/rgb_to_yuv420_block.sv */
// RGB to YUV 4:2:0 converter for one 2x2 pixel block per item.
//
// Input: raise start with the twelve blue, green and red bytes of the block;
// the item is taken at that clock edge. busy is always low, so an item may
// be given in every cycle and the throughput is one item per clock.
// Output: once the item has passed the four-stage pipeline (pixel products,
// chroma sums, reciprocal multiply for the divide by 1000, and rounding and
// clamping), result_valid is high for one cycle with the four luma values
// and the averaged U and V values. The receiver cannot stall; each result
// must be taken in the cycle it appears.
// Configuration: an APB-style port at byte address 0 holds chroma_offset in
// bits 7:0; it is added to U and V modulo 256. Write it only while no item is
// in flight. pready is always high.
// Reset: rst_n clears the pipeline valid flags, so no result follows reset,
// and sets chroma_offset to 128.
module rgb_to_yuv420_block (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       top_left_blue,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       top_left_green,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       top_left_red,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       top_right_blue,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       top_right_green,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       top_right_red,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       bottom_left_blue,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       bottom_left_green,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       bottom_left_red,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       bottom_right_blue,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       bottom_right_green,
    input  logic [rtyuv_pkg::SAMPLE_W-1:0]       bottom_right_red,
    output logic                                 result_valid,
    output logic [rtyuv_pkg::SAMPLE_W-1:0]       luma_top_left,
    output logic [rtyuv_pkg::SAMPLE_W-1:0]       luma_top_right,
    output logic [rtyuv_pkg::SAMPLE_W-1:0]       luma_bottom_left,
    output logic [rtyuv_pkg::SAMPLE_W-1:0]       luma_bottom_right,
    output logic [rtyuv_pkg::SAMPLE_W-1:0]       chroma_u_out,
    output logic [rtyuv_pkg::SAMPLE_W-1:0]       chroma_v_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rtyuv_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import rtyuv_pkg::*;

    logic                             valid1_reg;
    logic                             valid2_reg;
    logic                             valid3_reg;
    logic                             result_valid_reg;
    logic                             accept;
    logic                             cfg_write;
    logic                             offset_sel;
    logic [SAMPLE_W-1:0]              chroma_offset_reg;
    logic [SAMPLE_W-1:0]              chroma_offset_next;

    logic [LUMA_MILLI_W-1:0]          luma_milli [4];
    logic signed [U_MILLI_W-1:0]      u_milli    [4];
    logic signed [CHROMA_MILLI_W-1:0] v_milli    [4];
    logic signed [CHROMA_MILLI_W-1:0] u_milli_ext [4];
    logic [SAMPLE_W-1:0]              red_in   [4];
    logic [SAMPLE_W-1:0]              green_in [4];
    logic [SAMPLE_W-1:0]              blue_in  [4];
    logic [SAMPLE_W-1:0]              luma_out [4];

    // The pipeline never stalls, so a new item can be taken in every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Pixel order: top left, top right, bottom left, bottom right.
    always_comb
    begin
        red_in[0]   = top_left_red;
        green_in[0] = top_left_green;
        blue_in[0]  = top_left_blue;
        red_in[1]   = top_right_red;
        green_in[1] = top_right_green;
        blue_in[1]  = top_right_blue;
        red_in[2]   = bottom_left_red;
        green_in[2] = bottom_left_green;
        blue_in[2]  = bottom_left_blue;
        red_in[3]   = bottom_right_red;
        green_in[3] = bottom_right_green;
        blue_in[3]  = bottom_right_blue;
    end

    // Per-pixel products and luma paths.
    for (genvar p = 0; p < 4; p++)
    begin : g_pixel
        rtyuv_pixel u_pixel (
            .clk            (clk),
            .red            (red_in[p]),
            .green          (green_in[p]),
            .blue           (blue_in[p]),
            .luma_milli_reg (luma_milli[p]),
            .u_milli_reg    (u_milli[p]),
            .v_milli_reg    (v_milli[p])
        );

        assign u_milli_ext[p] = CHROMA_MILLI_W'(u_milli[p]);

        rtyuv_luma u_luma (
            .clk        (clk),
            .luma_milli (luma_milli[p]),
            .luma_reg   (luma_out[p])
        );
    end

    // Averaged chroma paths.
    rtyuv_chroma u_chroma_u (
        .clk        (clk),
        .milli_a    (u_milli_ext[0]),
        .milli_b    (u_milli_ext[1]),
        .milli_c    (u_milli_ext[2]),
        .milli_d    (u_milli_ext[3]),
        .offset     (chroma_offset_reg),
        .chroma_reg (chroma_u_out)
    );

    rtyuv_chroma u_chroma_v (
        .clk        (clk),
        .milli_a    (v_milli[0]),
        .milli_b    (v_milli[1]),
        .milli_c    (v_milli[2]),
        .milli_d    (v_milli[3]),
        .offset     (chroma_offset_reg),
        .chroma_reg (chroma_v_out)
    );

    assign luma_top_left     = luma_out[0];
    assign luma_top_right    = luma_out[1];
    assign luma_bottom_left  = luma_out[2];
    assign luma_bottom_right = luma_out[3];
    assign result_valid      = result_valid_reg;

    // Valid flags travel alongside the data stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg       <= 1'b0;
            valid2_reg       <= 1'b0;
            valid3_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            valid1_reg       <= accept;
            valid2_reg       <= valid1_reg;
            valid3_reg       <= valid2_reg;
            result_valid_reg <= valid3_reg;
        end
    end

    // Register access; the low two address bits are not decoded, only paddr[2] is.
    assign pready     = 1'b1;
    assign offset_sel = (paddr[2] == REG_IDX_CHROMA_OFFSET);
    assign cfg_write  = psel && penable && pwrite && pready;
    assign prdata     = offset_sel ? 32'(chroma_offset_reg) : 32'd0;

    always_comb
    begin
        chroma_offset_next = chroma_offset_reg;
        if (cfg_write && offset_sel)
        begin
            chroma_offset_next = pwdata[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chroma_offset_reg <= CHROMA_OFFSET_RESET;
        end
        else
        begin
            chroma_offset_reg <= chroma_offset_next;
        end
    end

    // An accepted item shows up on result_valid after the valid flag pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 result_valid)
        else $error("accepted item did not produce a result after four cycles");

    // No result appears without a matching accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##4 !result_valid)
        else $error("result appeared without an accepted item");

    // An all-black block gives zero top-left and bottom-right luma and offset chroma.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && top_left_red == 8'd0 && top_left_green == 8'd0
         && top_left_blue == 8'd0 && bottom_right_red == 8'd0
         && bottom_right_green == 8'd0 && bottom_right_blue == 8'd0
         && top_right_red == 8'd0 && top_right_green == 8'd0
         && top_right_blue == 8'd0 && bottom_left_red == 8'd0
         && bottom_left_green == 8'd0 && bottom_left_blue == 8'd0)
        |-> ##4 (luma_top_left == 8'd0 && luma_bottom_right == 8'd0
                 && chroma_u_out == $past(chroma_offset_reg)
                 && chroma_v_out == $past(chroma_offset_reg)))
        else $error("black block did not convert to zero luma and offset chroma");

endmodule
